FILE: rtl/sdg_pkg.sv
// shared constants for the spectral denoise gain block
package sdg_pkg;

    localparam int AMP_BITS_DEFAULT = 16;
    localparam int CFG_DATA_BITS    = 16;
    localparam int CFG_INDEX_BITS   = 2;
    localparam int OUT_FIELD_BITS   = 16;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_FOOTPRINT_MODE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NOISE_OFFSET   = 2'd1;

    // noise estimate source
    localparam logic [1:0] MODE_MAIN = 2'd0;
    localparam logic [1:0] MODE_SIDE = 2'd1;
    localparam logic [1:0] MODE_AVG  = 2'd2;

endpackage

FILE: rtl/spectral_denoise_gain.sv
// top level: out = min(main, main*main/(c+offset)), one item per cycle while the output is not stalled
// pipeline: front stage, AMP_BITS divider stages, output register
// throughput: one item per cycle unless the output stalls; the divider retires one quotient bit per stage
// each stage holds while its successor is full and stalled, bubbles close up
// reset (aresetn low, synchronous) empties the pipeline, mode to main, offset to 1
module spectral_denoise_gain
    import sdg_pkg::*;
#(
    parameter int AMP_BITS = AMP_BITS_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [AMP_BITS-1:0]       s_main_amp,
    input  logic [AMP_BITS-1:0]       s_side_amp,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [AMP_BITS-1:0]       m_out_amp,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int OFS_BITS = (AMP_BITS < CFG_DATA_BITS) ? AMP_BITS : CFG_DATA_BITS;
    localparam int OUT_BITS = (AMP_BITS < OUT_FIELD_BITS) ? AMP_BITS : OUT_FIELD_BITS;

    logic [1:0]            mode_reg;
    logic [AMP_BITS-1:0]   offset_reg, offset_next;
    logic [OFS_BITS-1:0]   ofs_wr;

    logic                  valid_w [0:AMP_BITS];
    logic                  ready_w [0:AMP_BITS];
    logic [AMP_BITS+1:0]   rem_w   [0:AMP_BITS];
    logic [AMP_BITS-1:0]   low_w   [0:AMP_BITS];
    logic [AMP_BITS+1:0]   den_w   [0:AMP_BITS];
    logic [AMP_BITS-1:0]   main_w  [0:AMP_BITS];
    logic                  sat_w   [0:AMP_BITS];

    logic                  out_valid_reg;
    logic [AMP_BITS-1:0]   out_amp_reg, out_amp_next;
    logic                  out_ready;

    assign cfg_ready = 1'b1;

    // a written offset of zero counts as one so the divisor never vanishes
    always_comb begin
        ofs_wr      = cfg_data[OFS_BITS-1:0];
        offset_next = (ofs_wr == '0) ? AMP_BITS'(1) : AMP_BITS'(ofs_wr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_MAIN;
            offset_reg <= AMP_BITS'(1);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_FOOTPRINT_MODE: mode_reg   <= cfg_data[1:0];
                REG_NOISE_OFFSET:   offset_reg <= offset_next;
                default:            ;
            endcase
        end
    end

    sdg_front #(
        .AMP_BITS (AMP_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .main_amp  (s_main_amp),
        .side_amp  (s_side_amp),
        .mode      (mode_reg),
        .offset    (offset_reg),
        .out_valid (valid_w[0]),
        .out_ready (ready_w[0]),
        .rem       (rem_w[0]),
        .low       (low_w[0]),
        .den       (den_w[0]),
        .main_out  (main_w[0]),
        .sat       (sat_w[0])
    );

    for (genvar i = 0; i < AMP_BITS; i++) begin : g_div
        sdg_div_stage #(
            .AMP_BITS (AMP_BITS)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_w[i]),
            .in_ready  (ready_w[i]),
            .rem_in    (rem_w[i]),
            .low_in    (low_w[i]),
            .den_in    (den_w[i]),
            .main_in   (main_w[i]),
            .sat_in    (sat_w[i]),
            .out_valid (valid_w[i+1]),
            .out_ready (ready_w[i+1]),
            .rem_out   (rem_w[i+1]),
            .low_out   (low_w[i+1]),
            .den_out   (den_w[i+1]),
            .main_out  (main_w[i+1]),
            .sat_out   (sat_w[i+1])
        );
    end

    // final remainder is not needed
    assign out_ready       = !out_valid_reg || m_ready;
    assign ready_w[AMP_BITS] = out_ready;

    always_comb begin
        out_amp_next = sat_w[AMP_BITS] ? main_w[AMP_BITS] : low_w[AMP_BITS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= valid_w[AMP_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            out_amp_reg <= out_amp_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_out_amp = AMP_BITS'(out_amp_reg[OUT_BITS-1:0]);

endmodule

FILE: rtl/sdg_front.sv
// front stage: noise estimate, divisor, saturation check and squaring of the main amplitude
module sdg_front
    import sdg_pkg::*;
#(
    parameter int AMP_BITS = AMP_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [AMP_BITS-1:0]   main_amp,
    input  logic [AMP_BITS-1:0]   side_amp,
    input  logic [1:0]            mode,
    input  logic [AMP_BITS-1:0]   offset,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [AMP_BITS+1:0]   rem,
    output logic [AMP_BITS-1:0]   low,
    output logic [AMP_BITS+1:0]   den,
    output logic [AMP_BITS-1:0]   main_out,
    output logic                  sat
);

    logic                  valid_reg;
    logic [AMP_BITS+1:0]   rem_reg, rem_next;
    logic [AMP_BITS-1:0]   low_reg, low_next;
    logic [AMP_BITS+1:0]   den_reg, den_next;
    logic [AMP_BITS-1:0]   main_reg;
    logic                  sat_reg, sat_next;

    logic [AMP_BITS-1:0]   lim;
    logic [AMP_BITS-1:0]   est;
    logic [2*AMP_BITS-1:0] sq;
    logic [2*AMP_BITS:0]   num;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        sq  = main_amp * main_amp;
        lim = (main_amp > offset) ? (main_amp - offset) : '0;
        est = (side_amp > lim) ? side_amp : lim;
        unique case (mode)
            MODE_AVG: begin
                // twice (c + offset), so the half of the mean is never rounded
                den_next = (AMP_BITS+2)'(main_amp) + (AMP_BITS+2)'(side_amp)
                         + (AMP_BITS+2)'({offset, 1'b0});
                sat_next = (AMP_BITS+2)'({main_amp, 1'b0}) >= den_next;
                num      = {sq, 1'b0};
            end
            MODE_SIDE: begin
                den_next = (AMP_BITS+2)'(est) + (AMP_BITS+2)'(offset);
                sat_next = (AMP_BITS+2)'(main_amp) >= den_next;
                num      = {1'b0, sq};
            end
            default: begin
                den_next = (AMP_BITS+2)'(main_amp) + (AMP_BITS+2)'(offset);
                sat_next = (AMP_BITS+2)'(main_amp) >= den_next;
                num      = {1'b0, sq};
            end
        endcase
        rem_next = (AMP_BITS+2)'(num[2*AMP_BITS:AMP_BITS]);
        low_next = num[AMP_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            rem_reg  <= rem_next;
            low_reg  <= low_next;
            den_reg  <= den_next;
            main_reg <= main_amp;
            sat_reg  <= sat_next;
        end
    end

    assign out_valid = valid_reg;
    assign rem       = rem_reg;
    assign low       = low_reg;
    assign den       = den_reg;
    assign main_out  = main_reg;
    assign sat       = sat_reg;

endmodule

FILE: rtl/sdg_div_stage.sv
// one restoring division step: one quotient bit per stage
module sdg_div_stage
    import sdg_pkg::*;
#(
    parameter int AMP_BITS = AMP_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [AMP_BITS+1:0]   rem_in,
    input  logic [AMP_BITS-1:0]   low_in,
    input  logic [AMP_BITS+1:0]   den_in,
    input  logic [AMP_BITS-1:0]   main_in,
    input  logic                  sat_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [AMP_BITS+1:0]   rem_out,
    output logic [AMP_BITS-1:0]   low_out,
    output logic [AMP_BITS+1:0]   den_out,
    output logic [AMP_BITS-1:0]   main_out,
    output logic                  sat_out
);

    logic                  valid_reg;
    logic [AMP_BITS+1:0]   rem_reg, rem_next;
    logic [AMP_BITS-1:0]   low_reg, low_next;
    logic [AMP_BITS+1:0]   den_reg;
    logic [AMP_BITS-1:0]   main_reg;
    logic                  sat_reg;

    logic [AMP_BITS+2:0]   trial;
    logic [AMP_BITS+2:0]   diff;
    logic                  ge;

    assign in_ready = !valid_reg || out_ready;

    // low word shifts out dividend bits at the top and takes quotient bits at the bottom
    always_comb begin
        trial    = {rem_in, low_in[AMP_BITS-1]};
        diff     = trial - {1'b0, den_in};
        ge       = trial >= {1'b0, den_in};
        rem_next = ge ? diff[AMP_BITS+1:0] : trial[AMP_BITS+1:0];
        low_next = {low_in[AMP_BITS-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            rem_reg  <= rem_next;
            low_reg  <= low_next;
            den_reg  <= den_in;
            main_reg <= main_in;
            sat_reg  <= sat_in;
        end
    end

    assign out_valid = valid_reg;
    assign rem_out   = rem_reg;
    assign low_out   = low_reg;
    assign den_out   = den_reg;
    assign main_out  = main_reg;
    assign sat_out   = sat_reg;

endmodule

FILE: verif/tb_top.sv
// self-checking testbench for the spectral denoise gain block
module tb_top
    import sdg_pkg::*;
();

    localparam int AMP_W        = AMP_BITS_DEFAULT;
    localparam int PIPE_CYCLES  = AMP_W + 2;
    localparam int ITEMS_PER_RUN = 100;
    localparam int RANDOM_RUNS  = 16;
    localparam int HOLD_AT      = 450;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 500000;

    // indexes and mode value with no function in the block
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;
    localparam logic [1:0]                MODE_SPARE  = 2'd3;

    typedef struct packed {
        logic [AMP_W-1:0] main_amp;
        logic [AMP_W-1:0] side_amp;
    } spec_bin_t;

    typedef struct packed {
        logic [AMP_W-1:0] main_amp;
        logic [AMP_W-1:0] side_amp;
        logic [AMP_W-1:0] out_amp;
    } denoised_bin_t;

    logic                      aclk       = 1'b0;
    logic                      aresetn    = 1'b0;
    logic                      s_valid    = 1'b0;
    logic                      s_ready;
    logic [AMP_W-1:0]          s_main_amp = '0;
    logic [AMP_W-1:0]          s_side_amp = '0;
    logic                      m_valid;
    logic                      m_ready    = 1'b0;
    logic [AMP_W-1:0]          m_out_amp;
    logic                      cfg_valid  = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index  = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data   = '0;

    spec_bin_t     bin_pending[$];
    denoised_bin_t denoised_expected[$];

    // shadow copy of the block's registers
    logic [1:0]               mode_shadow   = MODE_MAIN;
    logic [CFG_DATA_BITS-1:0] offset_shadow = 16'd1;

    int err_count     = 0;
    int bins_queued   = 0;
    int bins_accepted = 0;
    int results_seen  = 0;
    int burst_left    = 0;
    int gap_left      = 0;
    int rx_cycle      = 0;
    int rx_style      = 0;
    int rx_hold_left  = 0;
    bit rx_hold_fired = 1'b0;

    spectral_denoise_gain i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_main_amp (s_main_amp),
        .s_side_amp (s_side_amp),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_amp  (m_out_amp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #10 aclk = ~aclk;

    // denoised magnitude: min(m, m*m/(c+offset))
    function automatic logic [AMP_W-1:0] predict_out_amp(
        logic [AMP_W-1:0] main_amp, logic [AMP_W-1:0] side_amp,
        logic [1:0] mode, logic [CFG_DATA_BITS-1:0] offset);
        logic [63:0] m, s, o, lim, c, den, sq, q, r, res;
        m = main_amp;
        s = side_amp;
        o = (offset == 0) ? 64'd1 : offset;
        sq = m * m;
        if (mode == MODE_AVG) begin
            // twice the divisor, so half of c never rounds
            den = m + s + 2 * o;
            if (m >= s + 2 * o) begin
                res = m;
            end else begin
                q = sq / den;
                r = sq % den;
                res = 2 * q + (2 * r) / den;
            end
        end else begin
            if (mode == MODE_SIDE) begin
                lim = (m > o) ? m - o : 64'd0;
                c = (s > lim) ? s : lim;
            end else begin
                c = m;
            end
            den = c + o;
            res = (m >= den) ? m : sq / den;
        end
        if (res > m)
            res = m;
        return res[AMP_W-1:0];
    endfunction

    task automatic report_mismatch(string msg);
        err_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic push_bin(logic [AMP_W-1:0] main_amp, logic [AMP_W-1:0] side_amp);
        spec_bin_t b;
        b.main_amp = main_amp;
        b.side_amp = side_amp;
        bin_pending.push_back(b);
        bins_queued++;
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_FOOTPRINT_MODE)
            mode_shadow = data[1:0];
        else if (idx == REG_NOISE_OFFSET)
            offset_shadow = data;
    endtask

    // sender stays quiet until every queued item has come back
    task automatic wait_idle();
        while (results_seen != bins_queued)
            @(posedge aclk);
        repeat (PIPE_CYCLES + 4) @(posedge aclk);
    endtask

    // driver: bursts of items with random gaps
    always @(posedge aclk) begin : drive_bins
        spec_bin_t     b;
        denoised_bin_t e;
        int            r;
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready) begin
                e.main_amp = s_main_amp;
                e.side_amp = s_side_amp;
                e.out_amp  = predict_out_amp(s_main_amp, s_side_amp, mode_shadow, offset_shadow);
                denoised_expected.push_back(e);
                bins_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (burst_left == 0 && gap_left == 0) begin
                    burst_left = $urandom_range(1, 48);
                    r = $urandom_range(0, 9);
                    if (r < 4)
                        gap_left = 0;
                    else if (r < 8)
                        gap_left = $urandom_range(1, 4);
                    else
                        gap_left = $urandom_range(8, 30);
                end
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (bin_pending.size() != 0) begin
                    b = bin_pending.pop_front();
                    s_main_amp <= b.main_amp;
                    s_side_amp <= b.side_amp;
                    s_valid    <= 1'b1;
                    burst_left--;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // one long receiver hold so the pipeline fills and stalls its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_hold_left <= 0;
        end else if (!rx_hold_fired && bins_accepted >= HOLD_AT) begin
            rx_hold_fired <= 1'b1;
            rx_hold_left  <= HOLD_CYCLES;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // monitor: checks results in order and drives the stall pattern
    always @(posedge aclk) begin : check_results
        denoised_bin_t e;
        logic          ready_next;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (denoised_expected.size() == 0) begin
                    report_mismatch($sformatf("out_amp %0h with no item outstanding", m_out_amp));
                end else begin
                    e = denoised_expected.pop_front();
                    if (m_out_amp !== e.out_amp)
                        report_mismatch($sformatf("main %0h side %0h: out_amp %0h, predicted %0h",
                                                  e.main_amp, e.side_amp, m_out_amp, e.out_amp));
                end
            end
            rx_cycle++;
            if (rx_cycle % 128 == 0)
                rx_style = $urandom_range(0, 3);
            case (rx_style)
                0: ready_next = 1'b1;
                1: ready_next = 1'($urandom_range(0, 1));
                2: ready_next = (rx_cycle % 7) != 0;
                default: ready_next = ($urandom_range(0, 3) == 0);
            endcase
            m_ready <= ready_next && (rx_hold_left == 0);
        end
    end

    initial begin
        #(LIMIT_CYCLES * 20);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [AMP_W-1:0]         m, s;
        logic [CFG_DATA_BITS-1:0] offs;
        logic [13:0]              upper;
        logic [AMP_W-1:0]         corner[4];
        int                       k;
        corner[0] = '0;
        corner[1] = 1;
        corner[2] = '1 - 1;
        corner[3] = '1;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: main mode, offset one
        push_bin(0, 0);
        push_bin('1, '1);
        push_bin(1, '1);
        push_bin('1, 0);
        wait_idle();

        // side limit with the smallest offset, and main below the offset
        write_reg(REG_FOOTPRINT_MODE, {14'h0, MODE_SIDE});
        push_bin('1, 0);
        push_bin(0, '1);
        push_bin(16'h8000, 16'h8000);
        push_bin(1, 0);
        wait_idle();

        // largest offset: limit falls to zero
        write_reg(REG_NOISE_OFFSET, 16'hFFFF);
        push_bin('1, 0);
        push_bin(16'h1234, 0);
        wait_idle();

        // average mode, upper data bits set on the mode write
        write_reg(REG_FOOTPRINT_MODE, {14'h3FFF, MODE_AVG});
        write_reg(REG_NOISE_OFFSET, 16'd1);
        push_bin('1, 0);
        push_bin('1, '1);
        push_bin(0, '1);
        push_bin(16'd100, 16'd300);
        wait_idle();

        write_reg(REG_NOISE_OFFSET, 16'hFFFF);
        push_bin('1, '1);
        push_bin('1, 0);
        wait_idle();

        // spare mode acts as main, zero offset acts as one
        write_reg(REG_FOOTPRINT_MODE, {14'h0, MODE_SPARE});
        write_reg(REG_NOISE_OFFSET, 16'd0);
        push_bin('1, '1);
        push_bin(1, 0);
        push_bin(0, 0);
        wait_idle();

        // writes to unused indexes change nothing
        write_reg(REG_SPARE_2, 16'hFFFF);
        write_reg(REG_SPARE_3, 16'h0000);
        push_bin(16'hABCD, 16'h1234);
        wait_idle();

        for (int run = 0; run < RANDOM_RUNS; run++) begin
            upper = 14'($urandom_range(0, 16383));
            write_reg(REG_FOOTPRINT_MODE, {upper, 2'(run % 4)});
            case ((run / 4 + run) % 5)
                0: offs = 16'd1;
                1: offs = 16'hFFFF;
                2: offs = 16'd0;
                3: offs = CFG_DATA_BITS'($urandom_range(1, 255));
                default: offs = CFG_DATA_BITS'($urandom_range(0, 65535));
            endcase
            write_reg(REG_NOISE_OFFSET, offs);
            for (int i = 0; i < ITEMS_PER_RUN; i++) begin
                k = $urandom_range(0, 9);
                if (k == 0) begin
                    m = corner[$urandom_range(0, 3)];
                    s = corner[$urandom_range(0, 3)];
                end else if (k < 3) begin
                    m = AMP_W'($urandom_range(0, 64));
                    s = AMP_W'($urandom_range(0, 64));
                end else if (k < 5) begin
                    // side close to main minus the offset, around the limit boundary
                    m = AMP_W'($urandom_range(0, 65535));
                    s = m - offs + AMP_W'($urandom_range(0, 8)) - AMP_W'(4);
                end else begin
                    m = AMP_W'($urandom_range(0, 65535));
                    s = AMP_W'($urandom_range(0, 65535));
                end
                push_bin(m, s);
            end
            wait_idle();
        end

        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
